// ===== rtl/core/cvdp_pkg.sv =====
// ----------------------------------------------------------------------------
// cvdp_pkg: shared types and constants for the coupled oscillator evaluator
// Register indexes, the item record carried along the pipeline, the
// saturation result type and the fixed CORDIC tables.
// ----------------------------------------------------------------------------
package cvdp_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DETUNE_FIRST  = 3'd0,
		REG_DETUNE_SECOND = 3'd1,
		REG_COUPLING_GAIN = 3'd2,
		REG_DRIVE_FREQ    = 3'd3,
		REG_DRIVE_AMP     = 3'd4,
		REG_EXCITATION    = 3'd5
	} cfg_reg_t;

	// Input fields that travel with an item once the time has been consumed.
	typedef struct packed {
		logic signed [31:0] x1;
		logic signed [31:0] x2;
		logic signed [31:0] x3;
		logic signed [31:0] x4;
		logic signed [31:0] dx1;
		logic signed [31:0] dx2;
		logic signed [31:0] dx3;
		logic signed [31:0] dx4;
		logic signed [31:0] dt;
	} item_t;

	// A value clamped to 32 bits together with its clamp flag.
	typedef struct packed {
		logic               clip;
		logic signed [31:0] val;
	} sat_t;

	// Phase reduction: one compare and subtract per stage over a 64-bit magnitude.
	localparam int RED_N = 30;
	localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;

	// Reduced angle width, Q32 radians with sign.
	localparam int ANG_W = 36;
	localparam logic signed [ANG_W-1:0] PI_A      = 36'sd13493037705;
	localparam logic signed [ANG_W-1:0] HALF_PI_A = 36'sd6746518852;
	localparam logic signed [ANG_W-1:0] TWO_PI_A  = 36'sd26986075409;

	// atan(2^-i) in Q32.
	localparam logic [31:0] ATAN_Q32 [32] = '{
		32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
		32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
		32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
		32'd1048576,    32'd524288,     32'd262144,     32'd131072,
		32'd65536,      32'd32768,      32'd16384,      32'd8192,
		32'd4096,       32'd2048,       32'd1024,       32'd512,
		32'd256,        32'd128,        32'd64,         32'd32,
		32'd16,         32'd8,          32'd4,          32'd2
	};

	// Inverse CORDIC gain in Q30 for a given number of rotations.
	function automatic logic [31:0] cordic_gain(input int steps);
		logic [31:0] g;
		case (steps)
			12:      g = 32'd652032899;
			13:      g = 32'd652032880;
			14:      g = 32'd652032875;
			default: g = 32'd652032874;
		endcase
		return g;
	endfunction

endpackage

// ===== rtl/core/coupled_vdp_derivative_eval_unit.sv =====
// ----------------------------------------------------------------------------
// coupled_vdp_derivative_eval_unit: coupled driven Van der Pol evaluator
// Streams the state derivatives and the linearized perturbation derivatives
// of two coupled oscillators, with a CORDIC for the cosine drive.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                   Handshake
// -------   ---------------------------------------   ----------------------
// input     start, busy, pos_one .. pert_time          start & !busy
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid & cfg_ready
// result    done, rate_pos_one .. clipped              done, one cycle
//
// One item is taken every cycle; busy stays low. The pipeline has one stage
// each for f*t, its rounding and its magnitude, 30 compare/subtract stages
// for the modulo 2*pi reduction, two stages to finish the reduction, one to
// fold, one stage per CORDIC rotation, one to round cosine and sine and a
// product and sum pipeline of six stages.
// Reset clears the valid bits and the configuration registers.
// The result side cannot stall, so the pipeline never holds.
module coupled_vdp_derivative_eval_unit
	import cvdp_pkg::*;
#(
	parameter int FRAC_BITS    = 24,
	parameter int CORDIC_STEPS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic signed [31:0]   pos_one,
	input  logic signed [31:0]   vel_one,
	input  logic signed [31:0]   pos_two,
	input  logic signed [31:0]   vel_two,
	input  logic [31:0]          time_now,
	input  logic signed [31:0]   pert_pos_one,
	input  logic signed [31:0]   pert_vel_one,
	input  logic signed [31:0]   pert_pos_two,
	input  logic signed [31:0]   pert_vel_two,
	input  logic signed [31:0]   pert_time,
	output logic                 done,
	output logic signed [31:0]   rate_pos_one,
	output logic signed [31:0]   rate_vel_one,
	output logic signed [31:0]   rate_pos_two,
	output logic signed [31:0]   rate_vel_two,
	output logic signed [31:0]   pert_rate_pos_one,
	output logic signed [31:0]   pert_rate_vel_one,
	output logic signed [31:0]   pert_rate_pos_two,
	output logic signed [31:0]   pert_rate_vel_two,
	output logic                 clipped
);

	// Widths of rounded products and of exact sums.
	localparam int QW = 64 - FRAC_BITS;
	localparam int SW = QW + 3;
	localparam int AS = FRAC_BITS - 16;
	localparam int CS = 30 - FRAC_BITS;
	localparam int XW = 34;

	localparam logic signed [63:0]   QRND   = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [63:0]   ARND   = (64'sd1 <<< AS) >>> 1;
	localparam logic signed [XW-1:0] CRND   = (34'sd1 <<< CS) >>> 1;
	localparam logic signed [SW-1:0] ONE    = SW'(1) <<< FRAC_BITS;
	localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< 31) - SW'(1);
	localparam logic signed [SW-1:0] SAT_LO = -(SW'(1) <<< 31);
	localparam logic [31:0]          GAIN   = cordic_gain(CORDIC_STEPS);

	// Rounded fixed-point product, half an LSB up.
	function automatic logic signed [QW-1:0] qmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		p = p + QRND;
		return QW'(p >>> FRAC_BITS);
	endfunction

	// Clamp to the 32-bit signed range.
	function automatic sat_t sat32(input logic signed [SW-1:0] v);
		sat_t r;
		r.clip = (v > SAT_HI) || (v < SAT_LO);
		if (v > SAT_HI) begin
			r.val = 32'sh7FFFFFFF;
		end else if (v < SAT_LO) begin
			r.val = 32'sh80000000;
		end else begin
			r.val = v[31:0];
		end
		return r;
	endfunction

	// Configuration registers.
	logic signed [31:0] detune_first_q, detune_second_q, coupling_gain_q;
	logic signed [31:0] drive_freq_q, drive_amp_q, excitation_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detune_first_q  <= '0;
			detune_second_q <= '0;
			coupling_gain_q <= '0;
			drive_freq_q    <= '0;
			drive_amp_q     <= '0;
			excitation_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DETUNE_FIRST:  detune_first_q  <= cfg_data;
				REG_DETUNE_SECOND: detune_second_q <= cfg_data;
				REG_COUPLING_GAIN: coupling_gain_q <= cfg_data;
				REG_DRIVE_FREQ:    drive_freq_q    <= cfg_data;
				REG_DRIVE_AMP:     drive_amp_q     <= cfg_data;
				REG_EXCITATION:    excitation_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits of every stage.
	logic v_s1, v_s2, v_s4, v_s5, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic rv_s [RED_N+1];
	logic cv_s [CORDIC_STEPS+1];

	// Stage 1: drive phase product f*t.
	logic signed [63:0] prod_s1;
	item_t              it_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= drive_freq_q * $signed({1'b0, time_now});
		it_s1   <= '{x1: pos_one, x2: vel_one, x3: pos_two, x4: vel_two,
			dx1: pert_pos_one, dx2: pert_vel_one, dx3: pert_pos_two,
			dx4: pert_vel_two, dt: pert_time};
	end

	// Stage 2: round the phase to 32 fraction bits.
	logic signed [63:0] ang_s2;
	item_t              it_s2;

	always_ff @(posedge clk) begin
		ang_s2 <= (prod_s1 + ARND) >>> AS;
		it_s2  <= it_s1;
	end

	// Stage 3: magnitude and sign feed the reduction chain.
	logic [63:0] rm_s   [RED_N+1];
	logic        rneg_s [RED_N+1];
	item_t       rit_s  [RED_N+1];

	always_ff @(posedge clk) begin
		rneg_s[0] <= ang_s2[63];
		rm_s[0]   <= ang_s2[63] ? 64'(-ang_s2) : 64'(ang_s2);
		rit_s[0]  <= it_s2;
	end

	// Reduction chain: subtract 2*pi scaled by a falling power of two.
	for (genvar j = 0; j < RED_N; j++) begin : g_red
		localparam logic [63:0] STEP = TWO_PI_Q32 << (RED_N - 1 - j);
		always_ff @(posedge clk) begin
			rm_s[j+1]   <= (rm_s[j] >= STEP) ? (rm_s[j] - STEP) : rm_s[j];
			rneg_s[j+1] <= rneg_s[j];
			rit_s[j+1]  <= rit_s[j];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_s[j+1] <= 1'b0;
			end else begin
				rv_s[j+1] <= rv_s[j];
			end
		end
	end

	// Stage 4: a negative phase maps to 2*pi minus its remainder.
	logic [34:0] a0_s4;
	item_t       it_s4;
	logic [34:0] rem_last;

	assign rem_last = rm_s[RED_N][34:0];

	always_ff @(posedge clk) begin
		if (rneg_s[RED_N] && (rem_last != '0)) begin
			a0_s4 <= TWO_PI_Q32[34:0] - rem_last;
		end else begin
			a0_s4 <= rem_last;
		end
		it_s4 <= rit_s[RED_N];
	end

	// Stage 5: move the phase into (-pi, pi].
	logic signed [ANG_W-1:0] w_s5;
	logic signed [ANG_W-1:0] a0_ext;
	item_t                   it_s5;

	assign a0_ext = $signed({1'b0, a0_s4});

	always_ff @(posedge clk) begin
		w_s5  <= (a0_ext > PI_A) ? (a0_ext - TWO_PI_A) : a0_ext;
		it_s5 <= it_s4;
	end

	// Stage 6: fold into [-pi/2, pi/2] and load the rotator.
	logic signed [XW-1:0]    cx_s    [CORDIC_STEPS+1];
	logic signed [XW-1:0]    cy_s    [CORDIC_STEPS+1];
	logic signed [ANG_W-1:0] ca_s    [CORDIC_STEPS+1];
	logic                    cflip_s [CORDIC_STEPS+1];
	item_t                   cit_s   [CORDIC_STEPS+1];

	always_ff @(posedge clk) begin
		cx_s[0]  <= $signed({2'b00, GAIN});
		cy_s[0]  <= '0;
		cit_s[0] <= it_s5;
		if (w_s5 > HALF_PI_A) begin
			ca_s[0]    <= w_s5 - PI_A;
			cflip_s[0] <= 1'b1;
		end else if (w_s5 < -HALF_PI_A) begin
			ca_s[0]    <= w_s5 + PI_A;
			cflip_s[0] <= 1'b1;
		end else begin
			ca_s[0]    <= w_s5;
			cflip_s[0] <= 1'b0;
		end
	end

	// CORDIC rotations, one per stage.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		localparam logic signed [ANG_W-1:0] ATN = $signed({4'b0000, ATAN_Q32[i]});
		always_ff @(posedge clk) begin
			if (ca_s[i] >= 0) begin
				cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
				ca_s[i+1] <= ca_s[i] - ATN;
			end else begin
				cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
				ca_s[i+1] <= ca_s[i] + ATN;
			end
			cflip_s[i+1] <= cflip_s[i];
			cit_s[i+1]   <= cit_s[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else begin
				cv_s[i+1] <= cv_s[i];
			end
		end
	end

	// Stage 7: undo the fold and round cosine and sine to the value format.
	logic signed [XW-1:0] xf, yf, cosr, sinr;
	logic signed [31:0]   cos_s7, sin_s7;
	item_t                it_s7;

	assign xf   = cflip_s[CORDIC_STEPS] ? -cx_s[CORDIC_STEPS] : cx_s[CORDIC_STEPS];
	assign yf   = cflip_s[CORDIC_STEPS] ? -cy_s[CORDIC_STEPS] : cy_s[CORDIC_STEPS];
	assign cosr = (xf + CRND) >>> CS;
	assign sinr = (yf + CRND) >>> CS;

	always_ff @(posedge clk) begin
		cos_s7 <= cosr[31:0];
		sin_s7 <= sinr[31:0];
		it_s7  <= cit_s[CORDIC_STEPS];
	end

	// Stage 8: squares, cross products and the simple clamped sums.
	sat_t               sq1_c, sq3_c, af_c, k1_c, k2_c, sub13_c, sub31_c;
	logic signed [31:0] sq1_s8, sq3_s8, af_s8, k1_s8, k2_s8, sub13_s8, sub31_s8;
	logic signed [QW-1:0] qx12_s8, qx34_s8, ac_s8;
	logic signed [31:0]   sin_s8;
	logic                 clip_s8;
	item_t                it_s8;

	always_comb begin
		sq1_c   = sat32(SW'(qmul(it_s7.x1, it_s7.x1)));
		sq3_c   = sat32(SW'(qmul(it_s7.x3, it_s7.x3)));
		af_c    = sat32(SW'(qmul(drive_amp_q, drive_freq_q)));
		k1_c    = sat32(ONE + SW'(detune_first_q));
		k2_c    = sat32(ONE + SW'(detune_second_q));
		sub13_c = sat32(SW'(it_s7.x1) - SW'(it_s7.x3));
		sub31_c = sat32(SW'(it_s7.x3) - SW'(it_s7.x1));
	end

	always_ff @(posedge clk) begin
		sq1_s8   <= sq1_c.val;
		sq3_s8   <= sq3_c.val;
		af_s8    <= af_c.val;
		k1_s8    <= k1_c.val;
		k2_s8    <= k2_c.val;
		sub13_s8 <= sub13_c.val;
		sub31_s8 <= sub31_c.val;
		clip_s8  <= sq1_c.clip | sq3_c.clip | af_c.clip | k1_c.clip | k2_c.clip
			| sub13_c.clip | sub31_c.clip;
		qx12_s8  <= qmul(it_s7.x1, it_s7.x2);
		qx34_s8  <= qmul(it_s7.x3, it_s7.x4);
		ac_s8    <= qmul(drive_amp_q, cos_s7);
		sin_s8   <= sin_s7;
		it_s8    <= it_s7;
	end

	// Stage 9: damping terms and the linearized coefficients.
	sat_t               d1_c, d2_c, c1_c, c2_c;
	logic signed [31:0] damp1_s9, damp2_s9, c1_s9, c2_s9;
	logic signed [31:0] af_s9, k1_s9, k2_s9, sub13_s9, sub31_s9, sin_s9;
	logic signed [QW-1:0] ac_s9;
	logic                 clip_s9;
	item_t                it_s9;

	always_comb begin
		d1_c = sat32(SW'(excitation_q) - SW'(sq1_s8));
		d2_c = sat32(SW'(excitation_q) - SW'(sq3_s8));
		c1_c = sat32(-ONE - SW'(coupling_gain_q) - (SW'(qx12_s8) <<< 1)
			- SW'(detune_first_q));
		c2_c = sat32(-ONE - SW'(coupling_gain_q) - (SW'(qx34_s8) <<< 1)
			- SW'(detune_second_q));
	end

	always_ff @(posedge clk) begin
		damp1_s9 <= d1_c.val;
		damp2_s9 <= d2_c.val;
		c1_s9    <= c1_c.val;
		c2_s9    <= c2_c.val;
		clip_s9  <= clip_s8 | d1_c.clip | d2_c.clip | c1_c.clip | c2_c.clip;
		af_s9    <= af_s8;
		k1_s9    <= k1_s8;
		k2_s9    <= k2_s8;
		sub13_s9 <= sub13_s8;
		sub31_s9 <= sub31_s8;
		sin_s9   <= sin_s8;
		ac_s9    <= ac_s8;
		it_s9    <= it_s8;
	end

	// Stage 10: all remaining products that do not need the drive slope.
	logic signed [QW-1:0] m1_s10, m2_s10, m3_s10, m4_s10, m5_s10, m6_s10;
	logic signed [QW-1:0] m7_s10, m8_s10, m9_s10, m10_s10, m11_s10, m12_s10, m13_s10;
	logic signed [QW-1:0] ac_s10;
	logic                 clip_s10;
	item_t                it_s10;

	always_ff @(posedge clk) begin
		m1_s10   <= qmul(damp1_s9, it_s9.x2);
		m2_s10   <= qmul(k1_s9, it_s9.x1);
		m3_s10   <= qmul(coupling_gain_q, sub13_s9);
		m4_s10   <= qmul(damp2_s9, it_s9.x4);
		m5_s10   <= qmul(k2_s9, it_s9.x3);
		m6_s10   <= qmul(coupling_gain_q, sub31_s9);
		m7_s10   <= qmul(it_s9.dx1, c1_s9);
		m8_s10   <= qmul(it_s9.dx2, damp1_s9);
		m9_s10   <= qmul(it_s9.dx3, coupling_gain_q);
		m10_s10  <= qmul(af_s9, sin_s9);
		m11_s10  <= qmul(it_s9.dx3, c2_s9);
		m12_s10  <= qmul(it_s9.dx4, damp2_s9);
		m13_s10  <= qmul(it_s9.dx1, coupling_gain_q);
		ac_s10   <= ac_s9;
		clip_s10 <= clip_s9;
		it_s10   <= it_s9;
	end

	// Stage 11: the velocity rates, the second perturbation rate and a*f*sin.
	sat_t               r1_c, r3_c, r7_c, afs_c;
	logic signed [31:0] r1_s11, r3_s11, r7_s11, afs_s11;
	logic signed [SW-1:0] p5_s11;
	logic                 clip_s11;
	item_t                it_s11;

	always_comb begin
		r1_c  = sat32(SW'(m1_s10) - SW'(m2_s10) - SW'(m3_s10) + SW'(ac_s10));
		r3_c  = sat32(SW'(m4_s10) - SW'(m5_s10) - SW'(m6_s10));
		r7_c  = sat32(SW'(m11_s10) + SW'(m12_s10) + SW'(m13_s10));
		afs_c = sat32(SW'(m10_s10));
	end

	always_ff @(posedge clk) begin
		r1_s11   <= r1_c.val;
		r3_s11   <= r3_c.val;
		r7_s11   <= r7_c.val;
		afs_s11  <= afs_c.val;
		p5_s11   <= SW'(m7_s10) + SW'(m8_s10) + SW'(m9_s10);
		clip_s11 <= clip_s10 | r1_c.clip | r3_c.clip | r7_c.clip | afs_c.clip;
		it_s11   <= it_s10;
	end

	// Stage 12: drive slope term of the first perturbation rate.
	logic signed [QW-1:0] m14_s12;
	logic signed [31:0]   r1_s12, r3_s12, r7_s12;
	logic signed [SW-1:0] p5_s12;
	logic                 clip_s12;
	item_t                it_s12;

	always_ff @(posedge clk) begin
		m14_s12  <= qmul(it_s11.dt, afs_s11);
		r1_s12   <= r1_s11;
		r3_s12   <= r3_s11;
		r7_s12   <= r7_s11;
		p5_s12   <= p5_s11;
		clip_s12 <= clip_s11;
		it_s12   <= it_s11;
	end

	// Output register: last clamp and the result ports.
	sat_t r5_c;

	assign r5_c = sat32(p5_s12 - SW'(m14_s12));

	always_ff @(posedge clk) begin
		rate_pos_one      <= it_s12.x2;
		rate_vel_one      <= r1_s12;
		rate_pos_two      <= it_s12.x4;
		rate_vel_two      <= r3_s12;
		pert_rate_pos_one <= it_s12.dx2;
		pert_rate_vel_one <= r5_c.val;
		pert_rate_pos_two <= it_s12.dx4;
		pert_rate_vel_two <= r7_s12;
		clipped           <= clip_s12 | r5_c.clip;
	end

	// Valid bits outside the generated chains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			rv_s[0]  <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			cv_s[0]  <= 1'b0;
			v_s7     <= 1'b0;
			v_s8     <= 1'b0;
			v_s9     <= 1'b0;
			v_s10    <= 1'b0;
			v_s11    <= 1'b0;
			v_s12    <= 1'b0;
			done     <= 1'b0;
		end else begin
			v_s1     <= start && !busy;
			v_s2     <= v_s1;
			rv_s[0]  <= v_s2;
			v_s4     <= rv_s[RED_N];
			v_s5     <= v_s4;
			cv_s[0]  <= v_s5;
			v_s7     <= cv_s[CORDIC_STEPS];
			v_s8     <= v_s7;
			v_s9     <= v_s8;
			v_s10    <= v_s9;
			v_s11    <= v_s10;
			v_s12    <= v_s11;
			done     <= v_s12;
		end
	end

endmodule
